[rtl/rmst_pkg.sv]
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared widths, item codes and helpers for the range max segment tree.
// ----------------------------------------------------------------------------
`default_nettype none

package rmst_pkg;

  localparam int LEAVES_DEF = 1024;

  localparam int POS_W   = 10;
  localparam int VAL_W   = 32;
  localparam int BOUND_W = 11;

  typedef enum logic {
    ACT_RAISE = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  function automatic logic [VAL_W-1:0] max_val(input logic [VAL_W-1:0] x,
                                               input logic [VAL_W-1:0] y);
    max_val = (x > y) ? x : y;
  endfunction

endpackage

`default_nettype wire

[rtl/range_max_segment_tree_unit.sv]
// ----------------------------------------------------------------------------
// range_max_segment_tree_unit
// Max segment tree held in one synchronous memory; raises leaves and
// answers half-open range max queries.
//
//   channel | direction | ports
//   --------+-----------+---------------------------------------------------
//   in      | input     | in_valid/in_ready, action, position, value, bounds
//   out     | output    | out_valid/out_ready, range_max
//
// one item at a time; memory has one read and one write port, registered read
// raise: a read step and a write step per tree level, from the leaf up to the root
// query: a left step and a right step per level walked bottom-up, then output
// after reset all 2*LEAVES memory entries are cleared, in_ready low
// a finished result waits in the output register while the next item runs
// ----------------------------------------------------------------------------
`default_nettype none

module range_max_segment_tree_unit #(
  parameter int LEAVES = rmst_pkg::LEAVES_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_action,
  input  wire  [rmst_pkg::POS_W-1:0]   in_position,
  input  wire  [rmst_pkg::VAL_W-1:0]   in_value,
  input  wire  [rmst_pkg::BOUND_W-1:0] in_range_low,
  input  wire  [rmst_pkg::BOUND_W-1:0] in_range_high,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [rmst_pkg::VAL_W-1:0]   out_range_max
);
  import rmst_pkg::*;

  localparam int ADDR_W = $clog2(LEAVES) + 1;
  localparam int LIDX_W = ADDR_W + 1;
  localparam int DEPTH  = 2 * LEAVES;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UP_RD,
    S_UP_WR,
    S_Q_L,
    S_Q_R,
    S_Q_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [ADDR_W-1:0]   node_r, node_nxt;
  logic [VAL_W-1:0]    val_r, val_nxt;
  logic [LIDX_W-1:0]   l_r, l_nxt;
  logic [LIDX_W-1:0]   r_r, r_nxt;
  logic [VAL_W-1:0]    acc_r, acc_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]    out_max_r, out_max_nxt;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [VAL_W-1:0]    mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [VAL_W-1:0]    rdata_r;
  logic [VAL_W-1:0]    mem [DEPTH];

  logic [31:0]         pos_ext;
  logic [31:0]         lo_clamp;
  logic [31:0]         hi_clamp;

  // tree memory, entry 0 unused, node j has children 2j and 2j+1
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_range_max = out_max_r;

  assign pos_ext  = 32'(in_position);
  assign lo_clamp = (32'(in_range_low) > 32'(LEAVES)) ? 32'(LEAVES) : 32'(in_range_low);
  assign hi_clamp = (32'(in_range_high) > 32'(LEAVES)) ? 32'(LEAVES) : 32'(in_range_high);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    node_nxt      = node_r;
    val_nxt       = val_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    pend_nxt      = 1'b0;
    acc_nxt       = pend_r ? max_val(acc_r, rdata_r) : acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_max_nxt   = out_max_r;
    mem_we        = 1'b0;
    mem_waddr     = node_r;
    mem_wdata     = '0;
    mem_raddr     = node_r;

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (action_t'(in_action) == ACT_RAISE) begin
            if (pos_ext < 32'(LEAVES)) begin
              node_nxt  = ADDR_W'(pos_ext + 32'(LEAVES));
              val_nxt   = in_value;
              state_nxt = S_UP_RD;
            end
          end else begin
            acc_nxt = '0;
            if (lo_clamp < hi_clamp) begin
              l_nxt     = LIDX_W'(lo_clamp + 32'(LEAVES));
              r_nxt     = LIDX_W'(hi_clamp + 32'(LEAVES));
              state_nxt = S_Q_L;
            end else begin
              state_nxt = S_Q_OUT;
            end
          end
        end
      end
      S_UP_RD: begin
        mem_raddr = node_r;
        state_nxt = S_UP_WR;
      end
      S_UP_WR: begin
        // ancestors only grow, so each node on the path takes max with value
        mem_we    = 1'b1;
        mem_waddr = node_r;
        mem_wdata = max_val(rdata_r, val_r);
        node_nxt  = node_r >> 1;
        if (node_r == ADDR_W'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_UP_RD;
        end
      end
      S_Q_L: begin
        if (l_r >= r_r) begin
          state_nxt = S_Q_OUT;
        end else begin
          if (l_r[0]) begin
            mem_raddr = l_r[ADDR_W-1:0];
            pend_nxt  = 1'b1;
            l_nxt     = l_r + 1'b1;
          end
          state_nxt = S_Q_R;
        end
      end
      S_Q_R: begin
        if (r_r[0]) begin
          mem_raddr = ADDR_W'(r_r - 1'b1);
          pend_nxt  = 1'b1;
        end
        l_nxt     = l_r >> 1;
        r_nxt     = r_r >> 1;
        state_nxt = S_Q_L;
      end
      S_Q_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_max_nxt   = acc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    node_r    <= node_nxt;
    val_r     <= val_nxt;
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    acc_r     <= acc_nxt;
    out_max_r <= out_max_nxt;
  end

endmodule

`default_nettype wire

[rtl/rmst_checker.sv]
// ----------------------------------------------------------------------------
// rmst_checker
// Port-level checks for the range max segment tree, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          in_action,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire  [rmst_pkg::VAL_W-1:0]   out_range_max
);
  import rmst_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_range_max))
    else $error("result changed while stalled");

  // reset leaves the block busy clearing with no result pending
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ready or result right after reset");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken back to back");

  // a raise never produces a result
  a_raise_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_RAISE) && !out_valid |=> !out_valid)
    else $error("result after a raise item");

endmodule

bind range_max_segment_tree_unit rmst_checker u_rmst_checker (.*);

`default_nettype wire

[bench/range_max_segment_tree_unit_tb.sv]
// ----------------------------------------------------------------------------
// range_max_segment_tree_unit_tb
// Drives raise and query items into the range max segment tree over
// valid/ready. A directed table runs first, then a long random part.
// Queries are checked against a typed-in result where the table has one, else
// against a leaf-level copy of the tree kept in step with each accepted raise.
// Both sides idle at random; the receiver also holds off for a long stretch
// so that the block backs up, and the sender drains once mid-run.
// ----------------------------------------------------------------------------
`default_nettype none

module range_max_segment_tree_unit_tb;
  import rmst_pkg::*;

  localparam int LEAVES      = LEAVES_DEF;
  localparam int RAND_ITEMS  = 1880;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int DIR_N       = 22;

  typedef struct packed {
    action_t            act;
    logic [POS_W-1:0]   pos;
    logic [VAL_W-1:0]   val;
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
    logic               fixed;
    logic [VAL_W-1:0]   want;
  } stim_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  wire                in_ready;
  logic               in_action;
  logic [POS_W-1:0]   in_position;
  logic [VAL_W-1:0]   in_value;
  logic [BOUND_W-1:0] in_range_low;
  logic [BOUND_W-1:0] in_range_high;
  wire                out_valid;
  logic               out_ready;
  wire  [VAL_W-1:0]   out_range_max;

  logic               cur_fixed;
  logic [VAL_W-1:0]   cur_want;
  logic               sender_quiet;
  logic [VAL_W-1:0]   leaf_level [LEAVES];
  logic [VAL_W-1:0]   pending_maxima [$];
  logic [VAL_W-1:0]   oldest_max;
  int                 errors = 0;
  int                 results_seen = 0;
  int                 cycle_count = 0;
  bit                 held_off = 1'b0;

  // expected results are typed in only where they are obvious
  stim_t dir_rows [DIR_N] = '{
    '{ACT_QUERY, 10'h3FF, 32'hFFFF_FFFF, 11'd0,    11'd1024, 1'b1, 32'd0},
    '{ACT_QUERY, 10'd0,   32'd0,         11'd1024, 11'd1024, 1'b1, 32'd0},
    '{ACT_QUERY, 10'd5,   32'd7,         11'd2047, 11'd2047, 1'b1, 32'd0},
    '{ACT_QUERY, 10'd0,   32'd0,         11'd500,  11'd10,   1'b1, 32'd0},
    '{ACT_RAISE, 10'd0,   32'hFFFF_FFFF, 11'd2047, 11'd0,    1'b0, 32'd0},
    '{ACT_QUERY, 10'd0,   32'd0,         11'd0,    11'd1,    1'b1, 32'hFFFF_FFFF},
    '{ACT_RAISE, 10'd1023, 32'd1,        11'd0,    11'd2047, 1'b0, 32'd0},
    '{ACT_QUERY, 10'd0,   32'd0,         11'd1023, 11'd1024, 1'b1, 32'd1},
    '{ACT_QUERY, 10'd0,   32'd0,         11'd1023, 11'd2047, 1'b1, 32'd1},
    '{ACT_RAISE, 10'd1023, 32'd0,        11'd0,    11'd0,    1'b0, 32'd0},
    '{ACT_QUERY, 10'd0,   32'd0,         11'd1023, 11'd1024, 1'b0, 32'd0},
    '{ACT_RAISE, 10'd512, 32'h1234_5678, 11'd0,    11'd0,    1'b0, 32'd0},
    '{ACT_QUERY, 10'd0,   32'd0,         11'd1,    11'd1023, 1'b0, 32'd0},
    '{ACT_QUERY, 10'd0,   32'd0,         11'd0,    11'd2047, 1'b1, 32'hFFFF_FFFF},
    '{ACT_QUERY, 10'd0,   32'd0,         11'd513,  11'd1023, 1'b0, 32'd0},
    '{ACT_QUERY, 10'd0,   32'd0,         11'd1024, 11'd0,    1'b1, 32'd0},
    '{ACT_RAISE, 10'd511, 32'hFFFF_FFFE, 11'd1024, 11'd1024, 1'b0, 32'd0},
    '{ACT_QUERY, 10'h3FF, 32'hFFFF_FFFF, 11'd511,  11'd513,  1'b0, 32'd0},
    '{ACT_QUERY, 10'd0,   32'd0,         11'd0,    11'd0,    1'b1, 32'd0},
    '{ACT_RAISE, 10'd0,   32'd0,         11'd0,    11'd0,    1'b0, 32'd0},
    '{ACT_QUERY, 10'd0,   32'd0,         11'd1,    11'd2047, 1'b0, 32'd0},
    '{ACT_QUERY, 10'd0,   32'd0,         11'd2047, 11'd0,    1'b1, 32'd0}
  };

  range_max_segment_tree_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_position  (in_position),
    .in_value     (in_value),
    .in_range_low (in_range_low),
    .in_range_high(in_range_high),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_range_max(out_range_max)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void raise_leaf(input logic [POS_W-1:0] pos,
                                     input logic [VAL_W-1:0] val);
    if (int'(pos) < LEAVES && val > leaf_level[pos]) leaf_level[pos] = val;
  endfunction

  function automatic logic [VAL_W-1:0] span_peak(input logic [BOUND_W-1:0] lo,
                                                 input logic [BOUND_W-1:0] hi);
    int               a;
    int               b;
    logic [VAL_W-1:0] peak;
    a = (int'(lo) > LEAVES) ? LEAVES : int'(lo);
    b = (int'(hi) > LEAVES) ? LEAVES : int'(hi);
    peak = '0;
    for (int i = a; i < b; i++) if (leaf_level[i] > peak) peak = leaf_level[i];
    return peak;
  endfunction

  function automatic stim_t random_item();
    stim_t s;
    int    m;
    s.act   = ($urandom_range(99) < 45) ? ACT_RAISE : ACT_QUERY;
    s.fixed = 1'b0;
    s.want  = '0;
    case ($urandom_range(3))
      0: s.pos = ($urandom_range(1) != 0) ? 10'd1023 : 10'd0;
      1: s.pos = POS_W'($urandom_range(15));
      default: s.pos = POS_W'($urandom_range(1023));
    endcase
    case ($urandom_range(4))
      0: s.val = VAL_W'($urandom_range(255));
      1: s.val = 32'hFFFF_FFFF;
      2: s.val = $urandom() >> $urandom_range(31);
      default: s.val = $urandom();
    endcase
    m = $urandom_range(99);
    if (s.act == ACT_RAISE || m < 10) begin
      s.lo = BOUND_W'($urandom_range(2047));
      s.hi = BOUND_W'($urandom_range(2047));
    end else if (m < 20) begin
      s.hi = BOUND_W'($urandom_range(1024));
      s.lo = BOUND_W'($urandom_range(1024 - int'(s.hi)) + int'(s.hi));
    end else if (m < 35) begin
      s.lo = BOUND_W'($urandom_range(1023));
      s.hi = BOUND_W'(int'(s.lo) + 1 + $urandom_range(7));
      if (int'(s.hi) > 1024) s.hi = 11'd1024;
    end else begin
      s.lo = BOUND_W'($urandom_range(1024));
      s.hi = BOUND_W'(int'(s.lo) + $urandom_range(1024 - int'(s.lo)));
    end
    return s;
  endfunction

  task automatic offer(input stim_t s);
    @(negedge clk);
    while (!sender_quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= s.act;
    in_position   <= s.pos;
    in_value      <= s.val;
    in_range_low  <= s.lo;
    in_range_high <= s.hi;
    cur_fixed     <= s.fixed;
    cur_want      <= s.want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // scoreboard: results first, since they belong to earlier items
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_maxima.size() == 0) begin
          $error("unexpected item: range_max actual %h", out_range_max);
          errors++;
        end else begin
          oldest_max = pending_maxima.pop_front();
          if (out_range_max !== oldest_max) begin
            $error("range_max expected %h actual %h", oldest_max, out_range_max);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_action == ACT_QUERY)
          pending_maxima = {pending_maxima,
                            cur_fixed ? cur_want : span_peak(in_range_low, in_range_high)};
        else
          raise_leaf(in_position, in_value);
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && results_seen >= 150) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (results_seen >= 600 && results_seen < 800) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 8);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_action     = ACT_RAISE;
    in_position   = '0;
    in_value      = '0;
    in_range_low  = '0;
    in_range_high = '0;
    cur_fixed     = 1'b0;
    cur_want      = '0;
    sender_quiet  = 1'b0;
    for (int i = 0; i < LEAVES; i++) leaf_level[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) offer(dir_rows[i]);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == 1000) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_maxima.size() != 0) @(posedge clk);
      end
      sender_quiet = (i >= 1300 && i < 1600);
      offer(random_item());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_maxima.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/rmst_pkg.sv
rtl/range_max_segment_tree_unit.sv
rtl/rmst_checker.sv
bench/range_max_segment_tree_unit_tb.sv
